### rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and codes for the positional list store: operation and status
// codes, the command of one storage cell and the control word of a cell.
// ----------------------------------------------------------------------------
package plc_pkg;

    // Fixed payload widths of the request and reply channels.
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;

    // Request operations.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_GET    = 3'd3,
        OP_LOCATE = 3'd4,
        OP_PRIOR  = 3'd5,
        OP_NEXT   = 3'd6
    } op_t;

    // Reply status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_NOPRIOR  = 3'd3,
        ST_NONEXT   = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    // What a cell does with its element at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_cmd_t;

    // Control word handed to each cell.
    typedef struct packed {
        cell_cmd_t cmd;
        logic      cmp_en;
        logic      live;
    } cell_ctl_t;

endpackage

### rtl/plc_req_if.sv
// ----------------------------------------------------------------------------
// plc_req_if
// Request channel of the positional list store: valid/ready handshake with
// the operation, the position and the value of one item.
// ----------------------------------------------------------------------------
interface plc_req_if;

    logic                               valid;
    logic                               ready;
    logic [plc_pkg::OP_W-1:0]           op;
    logic [plc_pkg::POS_W-1:0]          position;
    logic signed [plc_pkg::VAL_W-1:0]   item_value;

    modport source (output valid, output op, output position, output item_value,
                    input ready);
    modport sink   (input valid, input op, input position, input item_value,
                    output ready);

endinterface

### rtl/plc_rsp_if.sv
// ----------------------------------------------------------------------------
// plc_rsp_if
// Reply channel of the positional list store: valid/ready handshake with the
// status, the value read, the located position and the list length.
// ----------------------------------------------------------------------------
interface plc_rsp_if;

    logic                               valid;
    logic                               ready;
    logic [plc_pkg::STATUS_W-1:0]       status;
    logic signed [plc_pkg::VAL_W-1:0]   result_value;
    logic [plc_pkg::POS_W-1:0]          found_position;
    logic [plc_pkg::POS_W-1:0]          list_length;

    modport source (output valid, output status, output result_value,
                    output found_position, output list_length, input ready);
    modport sink   (input valid, input status, input result_value,
                    input found_position, input list_length, output ready);

endinterface

### rtl/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell
// One storage cell of the list chain. It holds one element, can load a new
// value or take its left or right neighbor's element, and registers whether
// its element equals the search key.
// ----------------------------------------------------------------------------
module plc_cell #(
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                     clk,
    input  plc_pkg::cell_ctl_t       ctl,
    input  logic [ELEMENT_WIDTH-1:0] left_data,
    input  logic [ELEMENT_WIDTH-1:0] right_data,
    input  logic [ELEMENT_WIDTH-1:0] key,
    output logic [ELEMENT_WIDTH-1:0] data,
    output logic                     hit
);

    logic [ELEMENT_WIDTH-1:0] data_reg;
    logic                     hit_reg;

    // Element storage and match flag; both are payload and need no reset.
    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            plc_pkg::CELL_LOAD:       data_reg <= key;
            plc_pkg::CELL_FROM_LEFT:  data_reg <= left_data;
            plc_pkg::CELL_FROM_RIGHT: data_reg <= right_data;
            default:                  data_reg <= data_reg;
        endcase
        if (ctl.cmp_en)
        begin
            hit_reg <= ctl.live && (data_reg == key);
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

### rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to CAPACITY signed elements kept in a chain of cells.
// Insert and delete shift the chain of cells; search compares all cells
// at once and isolates the first match.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+----------------------------------------------------
//  req     | in        | op, position, item_value
//  rsp     | out       | status, result_value, found_position, list_length
//
//  An item goes through accept, select and execute: the accept edge registers
//  the request and the match flag of every cell, the select step isolates the
//  first match or decodes the position, and the execute step reads the chosen
//  cell, shifts the chain and loads the reply register. The select stage holds
//  the first-match carry chain and the execute stage the wide read-out selection.
//  Reset clears the element count and the control; cell contents are
//  undefined until written and need no clearing pass.
//  A stalled reply holds the execute cycle; a new item is accepted while the
//  previous reply still waits.
// ----------------------------------------------------------------------------
module positional_list_store #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    plc_req_if.sink   req,
    plc_rsp_if.source rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_EXEC
    } state_t;

    state_t                       state_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    plc_pkg::op_t                 op_reg;
    logic [plc_pkg::POS_W-1:0]    pos_reg;
    logic [ELEMENT_WIDTH-1:0]     key_reg;
    logic [CAPACITY-1:0]          sel_reg;
    logic [CAPACITY-1:0]          sel_next;
    plc_pkg::status_t             status_reg;
    plc_pkg::status_t             status_next;
    logic [plc_pkg::POS_W-1:0]    found_reg;
    logic [plc_pkg::POS_W-1:0]    found_next;

    logic                               rsp_valid_reg;
    plc_pkg::status_t                   rsp_status_reg;
    logic signed [plc_pkg::VAL_W-1:0]   rsp_value_reg;
    logic [plc_pkg::POS_W-1:0]          rsp_found_reg;
    logic [plc_pkg::POS_W-1:0]          rsp_length_reg;

    logic                         req_fire;
    logic                         exec_go;
    logic [63:0]                  in_ext;
    logic [ELEMENT_WIDTH-1:0]     in_key;
    logic [ELEMENT_WIDTH-1:0]     cell_key;
    logic [CMPW-1:0]              pos_ext;
    logic [CMPW-1:0]              cnt_ext;
    logic [CAPACITY-1:0]          live_vec;
    logic [CAPACITY-1:0]          hit_vec;
    logic [CAPACITY-1:0]          first_vec;
    logic [CAPACITY-1:0]          pos_sel;
    logic [CMPW-1:0]              first_pos;
    logic                         bad_ins;
    logic                         bad_rd;
    logic                         any_hit;
    logic                         prior_ok;
    logic                         next_ok;
    logic [ELEMENT_WIDTH-1:0]     read_data;
    logic [63:0]                  read_ext;
    logic [63:0]                  read_sext;

    logic [ELEMENT_WIDTH-1:0]     cell_data [CAPACITY];
    plc_pkg::cell_ctl_t           cell_ctl  [CAPACITY];

    // Handshake and key formation.
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign in_ext    = {{32{req.item_value[31]}}, req.item_value};
    assign in_key    = in_ext[ELEMENT_WIDTH-1:0];
    assign cell_key  = (state_reg == S_IDLE) ? in_key : key_reg;
    assign pos_ext   = CMPW'(pos_reg);
    assign cnt_ext   = CMPW'(count_reg);

    // Cells below the element count hold list entries.
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            live_vec[k] = (CMPW'(k) < cnt_ext);
        end
    end

    // Chain of cells.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_d;
        logic [ELEMENT_WIDTH-1:0] right_d;
        if (g == 0)
        begin : g_first
            assign left_d = cell_data[g];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        plc_cell #(
            .ELEMENT_WIDTH(ELEMENT_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[g]),
            .left_data (left_d),
            .right_data(right_d),
            .key       (cell_key),
            .data      (cell_data[g]),
            .hit       (hit_vec[g])
        );
    end

    // Select stage: isolate the first match and decode the position.
    always_comb
    begin
        first_vec = hit_vec & (~hit_vec + CAPACITY'(1));
        any_hit   = |hit_vec;
        prior_ok  = !first_vec[0];
        next_ok   = |((first_vec << 1) & live_vec);
        bad_ins   = (pos_reg == '0) || (pos_ext > cnt_ext + CMPW'(1));
        bad_rd    = (pos_reg == '0) || (pos_ext > cnt_ext);
        first_pos = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            pos_sel[k] = (pos_ext == CMPW'(k + 1));
            if (first_vec[k])
            begin
                first_pos = first_pos | CMPW'(k + 1);
            end
        end

        status_next = plc_pkg::ST_OK;
        sel_next    = '0;
        found_next  = '0;
        case (op_reg)
            plc_pkg::OP_INSERT:
            begin
                if (bad_ins)
                    status_next = plc_pkg::ST_BADPOS;
                else if (count_reg == CW'(CAPACITY))
                    status_next = plc_pkg::ST_FULL;
            end
            plc_pkg::OP_DELETE, plc_pkg::OP_GET:
            begin
                if (bad_rd)
                    status_next = plc_pkg::ST_BADPOS;
                else
                    sel_next = pos_sel;
            end
            plc_pkg::OP_LOCATE:
            begin
                if (!any_hit)
                    status_next = plc_pkg::ST_NOTFOUND;
                else
                    found_next = first_pos[plc_pkg::POS_W-1:0];
            end
            plc_pkg::OP_PRIOR:
            begin
                if (!any_hit)
                    status_next = plc_pkg::ST_NOTFOUND;
                else if (!prior_ok)
                    status_next = plc_pkg::ST_NOPRIOR;
                else
                    sel_next = first_vec >> 1;
            end
            plc_pkg::OP_NEXT:
            begin
                if (!any_hit)
                    status_next = plc_pkg::ST_NOTFOUND;
                else if (!next_ok)
                    status_next = plc_pkg::ST_NONEXT;
                else
                    sel_next = first_vec << 1;
            end
            default:
            begin
                status_next = plc_pkg::ST_OK;
            end
        endcase
    end

    // Execute stage: read the selected cell and sign-extend it.
    always_comb
    begin
        read_data = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (sel_reg[k])
            begin
                read_data = read_data | cell_data[k];
            end
        end
        read_ext = 64'(read_data);
        for (int i = 0; i < 64; i++)
        begin
            read_sext[i] = (i < ELEMENT_WIDTH) ? read_ext[i] : read_ext[ELEMENT_WIDTH-1];
        end
    end

    // Execute stage: count update.
    always_comb
    begin
        count_next = count_reg;
        if (exec_go)
        begin
            case (op_reg)
                plc_pkg::OP_CLEAR:
                    count_next = '0;
                plc_pkg::OP_INSERT:
                    if (status_reg == plc_pkg::ST_OK)
                        count_next = count_reg + CW'(1);
                plc_pkg::OP_DELETE:
                    if (status_reg == plc_pkg::ST_OK)
                        count_next = count_reg - CW'(1);
                default:
                    count_next = count_reg;
            endcase
        end
    end

    // Cell control: compare on accept, shift on a successful insert or delete.
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            cell_ctl[k].live   = live_vec[k];
            cell_ctl[k].cmp_en = req_fire;
            cell_ctl[k].cmd    = plc_pkg::CELL_HOLD;
            if (exec_go && (status_reg == plc_pkg::ST_OK))
            begin
                case (op_reg)
                    plc_pkg::OP_INSERT:
                    begin
                        if (pos_ext == CMPW'(k + 1))
                            cell_ctl[k].cmd = plc_pkg::CELL_LOAD;
                        else if (CMPW'(k) >= pos_ext)
                            cell_ctl[k].cmd = plc_pkg::CELL_FROM_LEFT;
                    end
                    plc_pkg::OP_DELETE:
                    begin
                        if (CMPW'(k + 1) >= pos_ext)
                            cell_ctl[k].cmd = plc_pkg::CELL_FROM_RIGHT;
                    end
                    default:
                    begin
                        cell_ctl[k].cmd = plc_pkg::CELL_HOLD;
                    end
                endcase
            end
        end
    end

    // Sequencer and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            case (state_reg)
                S_IDLE:
                    if (req_fire)
                        state_reg <= S_SEL;
                S_SEL:
                    state_reg <= S_EXEC;
                S_EXEC:
                    if (exec_go)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
            if (exec_go)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Request, select and reply payload registers.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= plc_pkg::op_t'(req.op);
            pos_reg <= req.position;
            key_reg <= in_key;
        end
        if (state_reg == S_SEL)
        begin
            sel_reg    <= sel_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
        if (exec_go)
        begin
            rsp_status_reg <= status_reg;
            rsp_value_reg  <= read_sext[plc_pkg::VAL_W-1:0];
            rsp_found_reg  <= found_reg;
            rsp_length_reg <= plc_pkg::POS_W'(count_next);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.result_value   = rsp_value_reg;
    assign rsp.found_position = rsp_found_reg;
    assign rsp.list_length    = rsp_length_reg;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    // The count only moves at the end of an execute cycle.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(count_reg))
        else $error("element count changed outside execute");

    // At most one cell is read out.
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(sel_reg))
        else $error("more than one cell selected");

    // A finished execute always presents a reply.
    a_reply: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> rsp_valid_reg)
        else $error("reply missing after execute");

endmodule
